### sv/ocf_pkg.sv
// Shared types and constants of the odometry complementary fuser.
// Used by every module of the block but ocf_fifo; depends on nothing.
package ocf_pkg;

	typedef enum logic [1:0] {
		OP_WHEEL  = 2'd0,
		OP_VISUAL = 2'd1,
		OP_TICK   = 2'd2,
		OP_CAL    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SRC_WHEEL    = 2'd0,
		SRC_BLEND    = 2'd1,
		SRC_FALLBACK = 2'd2
	} src_t;

	typedef enum logic [1:0] {
		REG_WEIGHT  = 2'd0,
		REG_NEAR    = 2'd1,
		REG_REJECT  = 2'd2,
		REG_SILENCE = 2'd3
	} reg_t;

	localparam int CFG_DW = 24;

	localparam logic [16:0] WEIGHT_ONE      = 17'd65536;
	localparam logic [16:0] WEIGHT_RESET    = 17'd19661;
	localparam logic [15:0] NEAR_BOX_RESET  = 16'd3277;
	localparam logic [23:0] REJECT_RESET    = 24'd32768;
	localparam logic [7:0]  SILENCE_RESET   = 8'd6;
	localparam logic [7:0]  AGE_MAX         = 8'd255;

	typedef struct packed {
		op_t               operation;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic signed [31:0] speed_x;
		logic signed [31:0] speed_y;
		logic signed [31:0] turn_rate;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [15:0] out_heading;
		logic signed [31:0] out_speed_x;
		logic signed [31:0] out_speed_y;
		logic signed [31:0] out_turn_rate;
		src_t              source;
	} result_t;

	// classified word handed from the front to the back
	typedef struct packed {
		sample_t s;
		logic    near;
	} item_t;

	typedef struct packed {
		logic [16:0] trust_weight;
		logic [15:0] near_origin_limit;
		logic [23:0] reject_distance;
		logic [7:0]  silence_ticks;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111)
			r = v[31:0];
		else if (v[35])
			r = 32'sh8000_0000;
		else
			r = 32'sh7fff_ffff;
		return r;
	endfunction

endpackage

### sv/ocf_fifo.sv
// Small register queue used on both sides of the execute stage.
// Generic in word width and depth; no package dependency.
module ocf_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

### sv/ocf_front.sv
// Front end: accepts sample words, tags the near-origin test, queues them.
// Depends on ocf_pkg and ocf_fifo.
module ocf_front
	import ocf_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  sample_t sample,
	output logic    full,
	input  cfg_t    cfg,
	input  logic    take,
	output logic    item_valid,
	output item_t   item
);
	item_t       cls;
	logic [32:0] abs_x, abs_y;
	logic [32:0] lim;
	logic        q_empty;

	always_comb begin
		abs_x = sample.pos_x[31] ? 33'(-{sample.pos_x[31], sample.pos_x})
		                         : {1'b0, sample.pos_x};
		abs_y = sample.pos_y[31] ? 33'(-{sample.pos_y[31], sample.pos_y})
		                         : {1'b0, sample.pos_y};
		lim   = {17'd0, cfg.near_origin_limit};
		cls.s    = sample;
		cls.near = (abs_x < lim) && (abs_y < lim);
	end

	ocf_fifo #(.W($bits(item_t)), .DEPTH(DEPTH)) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (cls),
		.rd    (take),
		.rdata (item),
		.full  (full),
		.empty (q_empty)
	);

	assign item_valid = !q_empty;

endmodule

### sv/ocf_back.sv
// Back end: holds the pose state and executes one queued word per cycle while the result queue has room.
// Depends on ocf_pkg.
module ocf_back
	import ocf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    item_valid,
	input  item_t   item,
	input  logic    out_room,
	output logic    take,
	output logic    res_valid,
	output result_t res
);
	logic signed [31:0] wheel_px_q, wheel_py_q, vis_px_q, vis_py_q, fused_px_q, fused_py_q;
	logic [15:0]        wheel_yaw_q, vis_yaw_q;
	logic               visual_valid_q, wheel_seen_q;
	logic [7:0]         wheel_age_q;

	// reject test
	logic signed [32:0] ddx, ddy;
	logic [32:0]        dx, dy, r_ext;
	logic [47:0]        sqx, sqy, sqr;
	logic [48:0]        sq_sum;
	logic               far, reject;

	// blend
	logic [16:0]        w_eff;
	logic signed [32:0] bdx, bdy;
	logic signed [50:0] prx, pry;
	logic signed [34:0] scx, scy;
	logic signed [35:0] sumx, sumy;
	logic signed [15:0] dyaw;
	logic signed [33:0] pryaw;
	logic signed [17:0] scyaw;
	logic signed [31:0] blend_x, blend_y;
	logic [15:0]        blend_yaw;

	logic [7:0]         age_next;
	logic               fire;

	assign take = item_valid && out_room;

	always_comb begin
		ddx   = 33'(item.s.pos_x) - 33'(fused_px_q);
		ddy   = 33'(item.s.pos_y) - 33'(fused_py_q);
		dx    = ddx[32] ? 33'(-ddx) : 33'(ddx);
		dy    = ddy[32] ? 33'(-ddy) : 33'(ddy);
		r_ext = {9'd0, cfg.reject_distance};
		sqx   = 48'(dx[23:0]) * 48'(dx[23:0]);
		sqy   = 48'(dy[23:0]) * 48'(dy[23:0]);
		sqr   = 48'(cfg.reject_distance) * 48'(cfg.reject_distance);
		sq_sum = {1'b0, sqx} + {1'b0, sqy};
		// squares only matter once both offsets fit inside the radius
		far    = (dx > r_ext) || (dy > r_ext) || (sq_sum > {1'b0, sqr});
		reject = item.near && far && visual_valid_q;

		w_eff = cfg.trust_weight[16] ? WEIGHT_ONE : cfg.trust_weight;

		bdx  = 33'(item.s.pos_x) - 33'(wheel_px_q);
		bdy  = 33'(item.s.pos_y) - 33'(wheel_py_q);
		prx  = 51'(bdx) * 51'($signed({1'b0, w_eff}));
		pry  = 51'(bdy) * 51'($signed({1'b0, w_eff}));
		scx  = 35'((prx + 51'sd32768) >>> 16);
		scy  = 35'((pry + 51'sd32768) >>> 16);
		sumx = 36'(wheel_px_q) + 36'(scx);
		sumy = 36'(wheel_py_q) + 36'(scy);
		blend_x = sat32(sumx);
		blend_y = sat32(sumy);

		// yaw difference wraps as a signed binary angle
		dyaw      = $signed(item.s.heading - wheel_yaw_q);
		pryaw     = 34'(dyaw) * 34'($signed({1'b0, w_eff}));
		scyaw     = 18'((pryaw + 34'sd32768) >>> 16);
		blend_yaw = wheel_yaw_q + scyaw[15:0];

		age_next = (wheel_age_q == AGE_MAX) ? AGE_MAX : wheel_age_q + 8'd1;
		fire     = visual_valid_q && wheel_seen_q && (age_next >= cfg.silence_ticks);
	end

	always_comb begin
		res_valid         = 1'b0;
		res.out_x         = blend_x;
		res.out_y         = blend_y;
		res.out_heading   = blend_yaw;
		res.out_speed_x   = item.s.speed_x;
		res.out_speed_y   = item.s.speed_y;
		res.out_turn_rate = item.s.turn_rate;
		res.source        = SRC_BLEND;
		case (item.s.operation)
			OP_WHEEL: begin
				res_valid       = take;
				res.out_x       = item.s.pos_x;
				res.out_y       = item.s.pos_y;
				res.out_heading = item.s.heading;
				res.source      = SRC_WHEEL;
			end
			OP_VISUAL: begin
				res_valid = take && !reject && (w_eff != '0);
			end
			OP_TICK: begin
				res_valid         = take && fire;
				res.out_x         = vis_px_q;
				res.out_y         = vis_py_q;
				res.out_heading   = vis_yaw_q;
				res.out_speed_x   = '0;
				res.out_speed_y   = '0;
				res.out_turn_rate = '0;
				res.source        = SRC_FALLBACK;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_px_q     <= '0;
			wheel_py_q     <= '0;
			wheel_yaw_q    <= '0;
			vis_px_q       <= '0;
			vis_py_q       <= '0;
			vis_yaw_q      <= '0;
			fused_px_q     <= '0;
			fused_py_q     <= '0;
			visual_valid_q <= 1'b0;
			wheel_seen_q   <= 1'b0;
			wheel_age_q    <= '0;
		end else if (take) begin
			case (item.s.operation)
				OP_WHEEL: begin
					wheel_px_q   <= item.s.pos_x;
					wheel_py_q   <= item.s.pos_y;
					wheel_yaw_q  <= item.s.heading;
					fused_px_q   <= item.s.pos_x;
					fused_py_q   <= item.s.pos_y;
					wheel_seen_q <= 1'b1;
					wheel_age_q  <= '0;
				end
				OP_VISUAL: begin
					if (!reject) begin
						vis_px_q       <= item.s.pos_x;
						vis_py_q       <= item.s.pos_y;
						vis_yaw_q      <= item.s.heading;
						visual_valid_q <= 1'b1;
						if (w_eff != '0) begin
							fused_px_q  <= blend_x;
							fused_py_q  <= blend_y;
						end
					end
				end
				OP_TICK: begin
					wheel_age_q <= age_next;
					if (fire) begin
						fused_px_q  <= vis_px_q;
						fused_py_q  <= vis_py_q;
					end
				end
				default: begin
					wheel_px_q     <= '0;
					wheel_py_q     <= '0;
					wheel_yaw_q    <= '0;
					vis_px_q       <= '0;
					vis_py_q       <= '0;
					vis_yaw_q      <= '0;
					fused_px_q     <= '0;
					fused_py_q     <= '0;
					visual_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

### sv/odometry_complementary_fuser.sv
// Top level of the odometry complementary fuser: config registers, front,
// back and result queue. Depends on ocf_pkg, ocf_front, ocf_back, ocf_fifo.
//
// Fuses wheel and visual 2D poses. Sample words go in through a push/full
// queue and results come out of a pop/empty queue; up to one word is accepted
// every cycle. Each word waits in the input queue and is then executed by the
// back end, which reads the pose registers and updates them on taking it;
// that execute step sets the rate at one word per cycle, and it only stalls
// while the result queue is full. Its result goes from the back end into the
// result queue and from there to the result ports. Wheel samples always give
// a result, visual samples give one when accepted with a nonzero weight, ticks
// give one on wheel silence once both a wheel and a visual pose are held,
// calibrate never does. Write configuration only while the block is idle.
module odometry_complementary_fuser
	import ocf_pkg::*;
#(
	parameter int IN_DEPTH  = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  sample_t           sample,
	output logic              empty,
	input  logic              pop,
	output result_t           result,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [CFG_DW-1:0] wr_data
);
	cfg_t    cfg_q;
	logic    item_valid, take, res_valid, out_full;
	item_t   item;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trust_weight      <= WEIGHT_RESET;
			cfg_q.near_origin_limit <= NEAR_BOX_RESET;
			cfg_q.reject_distance   <= REJECT_RESET;
			cfg_q.silence_ticks     <= SILENCE_RESET;
		end else if (wr_en) begin
			case (reg_t'(wr_index))
				REG_WEIGHT:  cfg_q.trust_weight      <= wr_data[16:0];
				REG_NEAR:    cfg_q.near_origin_limit <= wr_data[15:0];
				REG_REJECT:  cfg_q.reject_distance   <= wr_data[23:0];
				REG_SILENCE: cfg_q.silence_ticks     <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	ocf_front #(.DEPTH(IN_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample    (sample),
		.full      (full),
		.cfg       (cfg_q),
		.take      (take),
		.item_valid(item_valid),
		.item      (item)
	);

	ocf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(item_valid),
		.item      (item),
		.out_room  (!out_full),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	ocf_fifo #(.W($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_valid),
		.wdata (res),
		.rd    (pop),
		.rdata (result),
		.full  (out_full),
		.empty (empty)
	);

	// the back end never hands a word to a full result queue
	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_full)
		else $error("result word produced while result queue full");

	// a pushed word is waiting for the back end on the next cycle
	a_push_reaches_back: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> item_valid)
		else $error("accepted word missing at back end");

	// wheel results come only from wheel words
	a_wheel_source: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.source == SRC_WHEEL) |-> (item.s.operation == OP_WHEEL))
		else $error("wheel result from non-wheel word");

	// calibrate never produces a word
	a_cal_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.s.operation == OP_CAL) |-> !res_valid)
		else $error("calibrate produced a result");

endmodule
